/* src/text_console_writer_defines.svh */
// Assertion shorthands for the console checker.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TCW_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("console check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define TCW_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("console check failed");

`endif

/* src/tcw_pkg.sv */
package tcw_pkg;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } req_t;

  typedef struct packed {
    logic [10:0] cursor_pos;
    logic [15:0] cell_data;
  } rsp_t;

  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_BACK  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_BLANK   = 8'h20;
  localparam logic [7:0] ATTR_RESET   = 8'h70;

  localparam int PADDR_W = 3;
  localparam logic [0:0] REG_TEXT_ATTR = 1'b0;

endpackage

/* src/text_console_writer.sv */
// Channel   Direction  Handshake                 Payload
// req       in         req_valid / req_stall     tcw_pkg::req_t
// rsp       out        rsp_valid / rsp_stall     tcw_pkg::rsp_t
// apb       in         psel penable pwrite       paddr pwdata -> prdata
//
// Put, backspace, newline without scroll: accepted in IDLE, executed in EXEC,
// result registered in RESP; no new item is taken until the state is back in IDLE.
// Read cell adds RD_WAIT (registered RAM read); a read past the screen skips it.
// Scroll copies one cell a cycle, then DRAIN; clear blanks the cells in SWEEP.
// After rst a clearing pass (INIT) blanks the RAM under req_stall.
// A stalled result holds in the output register; the next item is still taken.
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  tcw_pkg::req_t               req,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output tcw_pkg::rsp_t               rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcw_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int PW    = (AW > 11) ? AW : 11;

  typedef enum logic [2:0] {
    INIT, IDLE, EXEC, SWEEP, SCROLL, DRAIN, RD_WAIT, RESP
  } state_t;

  state_t          state;
  logic [CW-1:0]   col;
  logic [RW-1:0]   row;
  logic [7:0]      attr;
  logic [15:0]     blank_word;
  logic [AW-1:0]   sc;
  req_t            cur;
  logic            pend;
  logic [AW-1:0]   pend_addr;
  logic            pend_mem;
  logic [15:0]     res_data;

  logic [PW-1:0]   pos_wide;
  logic [AW-1:0]   pos;
  logic            last_col;
  logic            last_row;
  logic            at_origin;
  logic [PW-1:0]   idx_wide;
  logic            idx_ok;
  logic            sc_last;
  logic            sc_copy;
  logic [AW:0]     scroll_src;
  logic            cfg_wr;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [15:0]     ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [15:0]     ram_rdata;

  assign pos_wide   = PW'(row) * PW'(COLUMNS) + PW'(col);
  assign pos        = pos_wide[AW-1:0];
  assign last_col   = (col == CW'(COLUMNS - 1));
  assign last_row   = (row == RW'(ROWS - 1));
  assign at_origin  = (col == '0) && (row == '0);
  assign idx_wide   = PW'(cur.cell_index);
  assign idx_ok     = (idx_wide < PW'(CELLS));
  assign sc_last    = (sc == AW'(CELLS - 1));
  assign sc_copy    = (sc < AW'(CELLS - COLUMNS));
  assign scroll_src = {1'b0, sc} + (AW+1)'(COLUMNS);
  assign cfg_wr     = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_TEXT_ATTR);

  assign req_stall = (state != IDLE);
  assign pready    = 1'b1;
  assign prdata    = (paddr[PADDR_W-1:2] == REG_TEXT_ATTR) ? {24'b0, attr} : 32'b0;

  // RAM port steering
  always_comb begin
    ram_we    = pend;
    ram_waddr = pend_addr;
    ram_wdata = pend_mem ? ram_rdata : blank_word;
    ram_raddr = (state == SCROLL) ? scroll_src[AW-1:0] : idx_wide[AW-1:0];
    case (state)
      INIT, SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sc;
        ram_wdata = blank_word;
      end
      EXEC: begin
        if (cur.req_type == REQ_PUT && cur.char_code != CHAR_NEWLINE) begin
          ram_we    = 1'b1;
          ram_waddr = pos;
          ram_wdata = {attr, cur.char_code};
        end else if (cur.req_type == REQ_BACK && !at_origin) begin
          ram_we    = 1'b1;
          ram_waddr = pos - 1'b1;
          ram_wdata = {attr, CHAR_BLANK};
        end
      end
      default: begin
      end
    endcase
  end

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= INIT;
      sc         <= '0;
      col        <= '0;
      row        <= '0;
      attr       <= ATTR_RESET;
      blank_word <= {ATTR_RESET, CHAR_BLANK};
      pend       <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        attr <= pwdata[7:0];
      end
      if (rsp_valid && !rsp_stall && state != RESP) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        INIT: begin
          if (sc_last) begin
            sc    <= '0;
            state <= IDLE;
          end else begin
            sc <= sc + 1'b1;
          end
        end
        IDLE: begin
          if (req_valid) begin
            cur   <= req;
            state <= EXEC;
          end
        end
        EXEC: begin
          res_data <= '0;
          case (cur.req_type)
            REQ_PUT: begin
              if (cur.char_code == CHAR_NEWLINE || last_col) begin
                col <= '0;
                if (last_row) begin
                  // scroll: copy rows up, then blank the bottom row
                  sc         <= '0;
                  blank_word <= {attr, CHAR_BLANK};
                  state      <= SCROLL;
                end else begin
                  row   <= row + 1'b1;
                  state <= RESP;
                end
              end else begin
                col   <= col + 1'b1;
                state <= RESP;
              end
            end
            REQ_BACK: begin
              state <= RESP;
              if (!at_origin) begin
                if (col == '0) begin
                  col <= CW'(COLUMNS - 1);
                  row <= row - 1'b1;
                end else begin
                  col <= col - 1'b1;
                end
              end
            end
            REQ_CLEAR: begin
              col        <= '0;
              row        <= '0;
              sc         <= '0;
              blank_word <= {attr, CHAR_BLANK};
              state      <= SWEEP;
            end
            default: begin
              if (idx_ok) begin
                state <= RD_WAIT;
              end else begin
                state <= RESP;
              end
            end
          endcase
        end
        SWEEP: begin
          if (sc_last) begin
            sc    <= '0;
            state <= RESP;
          end else begin
            sc <= sc + 1'b1;
          end
        end
        SCROLL: begin
          // read ahead one row; the write follows from the pend registers
          pend      <= 1'b1;
          pend_addr <= sc;
          pend_mem  <= sc_copy;
          sc        <= sc + 1'b1;
          if (sc_last) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          pend  <= 1'b0;
          sc    <= '0;
          state <= RESP;
        end
        RD_WAIT: begin
          res_data <= ram_rdata;
          state    <= RESP;
        end
        RESP: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid      <= 1'b1;
            rsp.cursor_pos <= pos_wide[10:0];
            rsp.cell_data  <= res_data;
            state          <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

/* src/tcw_ram.sv */
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/tcw_checker.sv */
`include "text_console_writer_defines.svh"

module tcw_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input tcw_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input tcw_pkg::rsp_t rsp
);

  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;

  logic [1:0] pend_type;
  logic [1:0] shown_type;

  // track the type of the item whose result sits on rsp
  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      pend_type <= req.req_type;
    end
    if (!rsp_valid || !rsp_stall) begin
      shown_type <= pend_type;
    end
  end

  `TCW_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
  `TCW_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
  `TCW_ASSERT_NOW(a_pos_range, rsp_valid, (CELLS > 2047) || (int'(rsp.cursor_pos) < CELLS))
  `TCW_ASSERT_NOW(a_data_zero, rsp_valid && shown_type != REQ_READ, rsp.cell_data == 16'h0)
  `TCW_ASSERT_NOW(a_clear_home, rsp_valid && shown_type == REQ_CLEAR, rsp.cursor_pos == 11'h0)

endmodule

bind text_console_writer tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_checker (.*);

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import tcw_pkg::*;

  localparam int COLS        = 80;
  localparam int ROW_COUNT   = 25;
  localparam int CELLS       = COLS * ROW_COUNT;
  localparam int CYCLE_LIMIT = 20_000_000;
  localparam int PHASE_ITEMS = 180;
  localparam int SPARE_REG   = 1;
  localparam logic [PADDR_W-1:0] ATTR_ADDR  = PADDR_W'({REG_TEXT_ATTR, 2'b00});
  localparam logic [PADDR_W-1:0] SPARE_ADDR = PADDR_W'(4 * SPARE_REG);

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic req_valid = 1'b0;
  logic req_stall;
  req_t req_item  = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp_item;

  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [31:0]        pwdata  = '0;
  logic [31:0]        prdata;
  logic               pready;

  always #5 clk = ~clk;

  text_console_writer #(
    .COLUMNS(COLS),
    .ROWS   (ROW_COUNT)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req_item),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Shadow copy of the screen, cursor and attribute register.
  logic [15:0] screen_shadow [CELLS];
  int          cur_col;
  int          cur_row;
  logic [7:0]  text_attr;

  req_t pending_requests [$];
  rsp_t expected_reports [$];
  rsp_t want_report;

  bit req_fire;
  bit rsp_got;
  bit req_idle_en;
  bit rsp_idle_en;
  int req_gap;
  int rsp_hold;

  int scroll_count;
  int fail_count;
  int checked_count;
  int accepted_count;
  int issued_count;
  int attr_writes;

  function automatic int idle_draw(bit en);
    return en ? int'($urandom_range(0, 15)) : 0;
  endfunction

  function void blank_screen();
    for (int i = 0; i < CELLS; i++) screen_shadow[i] = {text_attr, CHAR_BLANK};
  endfunction

  function void line_feed();
    cur_col = 0;
    if (cur_row + 1 >= ROW_COUNT) begin
      for (int i = 0; i < CELLS - COLS; i++) screen_shadow[i] = screen_shadow[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++) screen_shadow[i] = {text_attr, CHAR_BLANK};
      scroll_count++;
    end else begin
      cur_row++;
    end
  endfunction

  function automatic rsp_t apply_request(req_t r);
    rsp_t o;
    o.cell_data = '0;
    case (r.req_type)
      REQ_PUT: begin
        if (r.char_code == CHAR_NEWLINE) begin
          line_feed();
        end else begin
          screen_shadow[cur_row * COLS + cur_col] = {text_attr, r.char_code};
          cur_col++;
          if (cur_col >= COLS) line_feed();
        end
      end
      REQ_BACK: begin
        // at the origin nothing moves and nothing is blanked
        if (cur_col != 0 || cur_row != 0) begin
          if (cur_col == 0) begin
            cur_col = COLS - 1;
            cur_row--;
          end else begin
            cur_col--;
          end
          screen_shadow[cur_row * COLS + cur_col] = {text_attr, CHAR_BLANK};
        end
      end
      REQ_CLEAR: begin
        blank_screen();
        cur_col = 0;
        cur_row = 0;
      end
      REQ_READ: begin
        if (r.cell_index < CELLS) o.cell_data = screen_shadow[r.cell_index];
      end
    endcase
    o.cursor_pos = 11'(cur_row * COLS + cur_col);
    return o;
  endfunction

  function void queue_request(logic [1:0] kind, logic [7:0] ch, logic [10:0] idx);
    req_t r;
    r.req_type   = kind;
    r.char_code  = (kind == REQ_PUT)  ? ch  : 8'($urandom);
    r.cell_index = (kind == REQ_READ) ? idx : 11'($urandom);
    pending_requests.push_back(r);
    issued_count++;
  endfunction

  // Request driver: hold a stalled item, otherwise idle or present the next one.
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      req_gap   <= 0;
    end else if (!req_valid || req_fire) begin
      if (req_gap != 0) begin
        req_valid <= 1'b0;
        req_gap   <= req_gap - 1;
      end else if (pending_requests.size() != 0) begin
        req_item  <= pending_requests.pop_front();
        req_valid <= 1'b1;
        req_gap   <= idle_draw(req_idle_en);
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Result side: stall for a drawn number of cycles after each item.
  always @(negedge clk) begin : rsp_pace
    int n;
    if (rst) begin
      rsp_stall <= 1'b0;
      rsp_hold  <= 0;
    end else if (rsp_got) begin
      n = idle_draw(rsp_idle_en);
      rsp_stall <= (n != 0);
      rsp_hold  <= (n != 0) ? n - 1 : 0;
    end else if (rsp_hold != 0) begin
      rsp_stall <= 1'b1;
      rsp_hold  <= rsp_hold - 1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    req_fire <= !rst && req_valid && !req_stall;
    rsp_got  <= !rst && rsp_valid && !rsp_stall;
    // check the result before booking the new item: it cannot be its own
    if (!rst && rsp_valid && !rsp_stall) begin
      checked_count <= checked_count + 1;
      if (expected_reports.size() == 0) begin
        $error("result with no request outstanding: cursor_pos %0d, cell_data %h",
               rsp_item.cursor_pos, rsp_item.cell_data);
        fail_count++;
      end else begin
        want_report = expected_reports.pop_front();
        if (rsp_item.cursor_pos !== want_report.cursor_pos) begin
          $error("cursor_pos: expected %0d, got %0d",
                 want_report.cursor_pos, rsp_item.cursor_pos);
          fail_count++;
        end
        if (rsp_item.cell_data !== want_report.cell_data) begin
          $error("cell_data: expected %h, got %h", want_report.cell_data, rsp_item.cell_data);
          fail_count++;
        end
      end
    end
    if (!rst && req_valid && !req_stall) begin
      expected_reports.push_back(apply_request(req_item));
      accepted_count <= accepted_count + 1;
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic wait_idle();
    while (accepted_count != issued_count || expected_reports.size() != 0) @(negedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (wr && addr == ATTR_ADDR) text_attr = wdata[7:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write a register while idle, then read the attribute back.
  task automatic write_register(logic [PADDR_W-1:0] addr, logic [31:0] value);
    logic [31:0] rd;
    wait_idle();
    apb_access(1'b1, addr, value, rd);
    apb_access(1'b0, ATTR_ADDR, 32'($urandom), rd);
    if (rd[7:0] !== text_attr) begin
      $error("text_attribute readback: expected %h, got %h", text_attr, rd[7:0]);
      fail_count++;
    end
    if (addr == ATTR_ADDR) attr_writes++;
  endtask

  initial begin : stimulus
    int          n;
    int          kind;
    int          pos;
    int          sel;
    int          phase_end;
    logic [7:0]  ch;
    logic [7:0]  attr_val;

    text_attr = ATTR_RESET;
    blank_screen();
    cur_col = 0;
    cur_row = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset contents, out-of-range reads, backspace at the origin,
    // extreme characters, newline, backspace across a row, clear.
    queue_request(REQ_READ, 8'h00, 11'd0);
    queue_request(REQ_READ, 8'h00, 11'(CELLS - 1));
    queue_request(REQ_READ, 8'h00, 11'(CELLS));
    queue_request(REQ_READ, 8'h00, 11'h7FF);
    queue_request(REQ_BACK, 8'h00, 11'd0);
    queue_request(REQ_PUT, 8'h41, 11'd0);
    queue_request(REQ_PUT, 8'h00, 11'd0);
    queue_request(REQ_PUT, 8'hFF, 11'd0);
    queue_request(REQ_PUT, CHAR_NEWLINE, 11'd0);
    queue_request(REQ_BACK, 8'h00, 11'd0);
    queue_request(REQ_READ, 8'h00, 11'(COLS - 1));
    queue_request(REQ_READ, 8'h00, 11'd2);
    queue_request(REQ_CLEAR, 8'h00, 11'd0);
    queue_request(REQ_READ, 8'h00, 11'd1);
    // a register beyond the list must leave the attribute alone
    write_register(SPARE_ADDR, $urandom);

    for (int phase = 0; phase < 8; phase++) begin
      if (phase != 0) begin
        attr_val = (phase == 1) ? 8'h00 :
                   (phase == 2) ? 8'hFF :
                   (phase == 4) ? 8'h0F :
                   (phase == 5) ? 8'hF0 : 8'($urandom);
        write_register(ATTR_ADDR, {24'($urandom), attr_val});
      end
      phase_end = issued_count + PHASE_ITEMS;
      while (issued_count < phase_end) begin
        req_idle_en <= ($urandom_range(0, 3) != 0);
        rsp_idle_en <= ($urandom_range(0, 3) != 0);
        kind = $urandom_range(0, 99);
        if (kind < 55) begin
          n = ($urandom_range(0, 3) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
          for (int i = 0; i < n; i++) begin
            ch = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(32, 126));
            queue_request(REQ_PUT, ch, 11'd0);
          end
          if ($urandom_range(0, 1)) queue_request(REQ_PUT, CHAR_NEWLINE, 11'd0);
        end else if (kind < 70) begin
          n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 90) : $urandom_range(1, 6);
          for (int i = 0; i < n; i++) queue_request(REQ_BACK, 8'h00, 11'd0);
        end else if (kind < 90) begin
          // aim reads at recent output: let the shadow catch up first
          while (accepted_count != issued_count) @(negedge clk);
          n = $urandom_range(1, 6);
          for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 50) begin
              pos = cur_row * COLS + cur_col - int'($urandom_range(0, 170));
              if (pos < 0) pos = 0;
            end else if (sel < 85) begin
              pos = $urandom_range(0, CELLS - 1);
            end else begin
              pos = $urandom_range(0, 2047);
            end
            queue_request(REQ_READ, 8'h00, 11'(pos));
          end
        end else if (kind < 96) begin
          n = $urandom_range(1, 30);
          for (int i = 0; i < n; i++) queue_request(REQ_PUT, CHAR_NEWLINE, 11'd0);
        end else if (kind < 98) begin
          queue_request(REQ_CLEAR, 8'h00, 11'd0);
        end else begin
          n = $urandom_range(1, 4);
          for (int i = 0; i < n; i++) queue_request(2'($urandom), 8'($urandom), 11'($urandom));
        end
        // keep a few items queued ahead of the driver
        while (pending_requests.size() > 4) @(negedge clk);
      end
    end

    wait_idle();
    repeat (50) @(posedge clk);
    $display("Console run: %0d requests accepted, %0d results compared, %0d screen scrolls.",
             accepted_count, checked_count, scroll_count);
    $display("Attribute register set %0d times, final value %h.", attr_writes, text_attr);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
